/* rtl/plsu_pkg.sv */
// ----------------------------------------------------------------------------
// plsu_pkg
// Shared types and constants of the positional list store unit.
// ----------------------------------------------------------------------------
package plsu_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam int REQ_W    = 2;
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int EIDX_W   = 6;
	localparam int ECNT_W   = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 2'd0,
		REQ_UPDATE = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_VIEW   = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_VIEW
	} state_t;

	typedef struct packed {
		logic op_exec;
		logic view_begin;
		logic view_emit;
	} plsu_cmd_t;

	typedef struct packed {
		logic out_free;
		logic list_empty;
		logic view_last;
		logic req_is_view;
	} plsu_sts_t;

endpackage

/* rtl/plsu_req_if.sv */
// ----------------------------------------------------------------------------
// plsu_req_if
// Request channel: valid/ready transfer of one list request.
// ----------------------------------------------------------------------------
interface plsu_req_if;
	import plsu_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] value;

	modport source (output valid, output req_type, output position, output value,
		input ready);
	modport sink (input valid, input req_type, input position, input value,
		output ready);

endinterface

/* rtl/plsu_rsp_if.sv */
// ----------------------------------------------------------------------------
// plsu_rsp_if
// Result channel: valid/ready transfer of one result item.
// ----------------------------------------------------------------------------
interface plsu_rsp_if;
	import plsu_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    entry_value;
	logic [EIDX_W-1:0]   entry_index;
	logic [ECNT_W-1:0]   entry_count;
	logic                last;

	modport source (output valid, output status, output entry_value,
		output entry_index, output entry_count, output last, input ready);
	modport sink (input valid, input status, input entry_value,
		input entry_index, input entry_count, input last, output ready);

endinterface

/* rtl/plsu_ctrl.sv */
// ----------------------------------------------------------------------------
// plsu_ctrl
// Request sequencer: accepts requests and steps view streaming.
// ----------------------------------------------------------------------------
module plsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  plsu_pkg::plsu_sts_t sts,
	output plsu_pkg::plsu_cmd_t cmd
);
	import plsu_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && sts.req_is_view && !sts.list_empty) begin
					state_d = S_VIEW;
				end
			end
			S_VIEW: begin
				if (sts.out_free && sts.view_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = sts.out_free;
				if (accept) begin
					if (sts.req_is_view && !sts.list_empty) begin
						cmd.view_begin = 1'b1;
					end else begin
						cmd.op_exec = 1'b1;
					end
				end
			end
			S_VIEW: begin
				cmd.view_emit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/plsu_dp.sv */
// ----------------------------------------------------------------------------
// plsu_dp
// Entry store, count, view index and result register.
// ----------------------------------------------------------------------------
module plsu_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [plsu_pkg::REQ_W-1:0]    req_type,
	input  logic [plsu_pkg::POS_W-1:0]    position,
	input  logic [plsu_pkg::VAL_W-1:0]    value,
	input  plsu_pkg::plsu_cmd_t           cmd,
	output plsu_pkg::plsu_sts_t           sts,
	plsu_rsp_if.source                    rsp
);
	import plsu_pkg::*;

	logic [VAL_W-1:0]    entries_q [DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    vidx_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VAL_W-1:0]    value_q;
	logic [EIDX_W-1:0]   index_q;
	logic [ECNT_W-1:0]   ecount_q;
	logic                last_q;

	req_t                req;
	logic                pos_ok;
	logic                full;
	logic [IDX_W-1:0]    pos_idx;
	logic [IDX_W-1:0]    tail_idx;
	logic                wr_app;
	logic                wr_upd;
	logic                wr_del;
	status_t             op_status;
	logic [CNT_W-1:0]    count_d;

	assign req      = req_t'(req_type);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign pos_ok   = ({{(POS_W > CNT_W ? POS_W - CNT_W : 0){1'b0}}, count_q} >
		POS_W'(position));
	assign pos_idx  = position[IDX_W-1:0];
	assign tail_idx = count_q[IDX_W-1:0];

	always_comb begin
		wr_app    = 1'b0;
		wr_upd    = 1'b0;
		wr_del    = 1'b0;
		op_status = ST_OK;
		count_d   = count_q;
		unique case (req)
			REQ_APPEND: begin
				if (full) begin
					op_status = ST_FULL;
				end else begin
					wr_app  = cmd.op_exec;
					count_d = count_q + CNT_W'(1);
				end
			end
			REQ_UPDATE: begin
				if (!pos_ok) begin
					op_status = ST_BADPOS;
				end else begin
					wr_upd = cmd.op_exec;
				end
			end
			REQ_DELETE: begin
				if (!pos_ok) begin
					op_status = ST_BADPOS;
				end else begin
					wr_del  = cmd.op_exec;
					count_d = count_q - CNT_W'(1);
				end
			end
			REQ_VIEW: begin
				op_status = ST_EMPTY;
			end
			default: op_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (wr_app && tail_idx == IDX_W'(i)) begin
				entries_q[i] <= value;
			end else if (wr_upd && pos_idx == IDX_W'(i)) begin
				entries_q[i] <= value;
			end else if (wr_del && IDX_W'(i) >= pos_idx && i < DEPTH - 1) begin
				entries_q[i] <= entries_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vidx_q  <= '0;
		end else begin
			if (cmd.op_exec) begin
				count_q <= count_d;
			end
			if (cmd.view_begin) begin
				vidx_q <= '0;
			end else if (cmd.view_emit) begin
				vidx_q <= vidx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op_exec || cmd.view_emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_exec) begin
			status_q <= op_status;
			value_q  <= '0;
			index_q  <= '0;
			ecount_q <= ECNT_W'(count_d);
			last_q   <= 1'b1;
		end else if (cmd.view_emit) begin
			status_q <= ST_OK;
			value_q  <= entries_q[vidx_q];
			index_q  <= EIDX_W'(vidx_q);
			ecount_q <= ECNT_W'(count_q);
			last_q   <= sts.view_last;
		end
	end

	assign sts.out_free    = !out_valid_q || rsp.ready;
	assign sts.list_empty  = (count_q == '0);
	assign sts.view_last   = ((CNT_W'(vidx_q) + CNT_W'(1)) == count_q);
	assign sts.req_is_view = (req == REQ_VIEW);

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_value = value_q;
	assign rsp.entry_index = index_q;
	assign rsp.entry_count = ecount_q;
	assign rsp.last        = last_q;

endmodule

/* rtl/positional_list_store_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Bounded ordered list of signed 32-bit values with positional requests.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready): append, update at position, delete at
// position and view. Results leave on rsp (valid/ready) from a result
// register, with a last marker on the final result of each request.
// Append, update and delete give one result each; delete closes the gap
// with a parallel shift of the entry row. A view gives one result per entry,
// one per cycle while the receiver takes them, streamed by the view index
// counter after the accepted view clears it; no request is taken until the
// view's last entry is loaded. A view of an empty list gives one empty status.
// Sustained rate: one request per cycle for append, update and delete while
// the receiver takes every result. Reset clears the count, the view index,
// the sequencer and the result valid flag; entry words and result fields
// are not cleared. When the receiver stalls, the result holds and req.ready
// drops until the result register can take a new transfer.
// ----------------------------------------------------------------------------
module positional_list_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	plsu_req_if.sink    req,
	plsu_rsp_if.source  rsp
);
	import plsu_pkg::*;

	plsu_cmd_t cmd;
	plsu_sts_t sts;
	logic      in_ready;

	assign req.ready = in_ready;

	plsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plsu_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_type (req.req_type),
		.position (req.position),
		.value    (req.value),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

/* tb/sv/tb_positional_list_store_unit.sv */
// ----------------------------------------------------------------------------
// tb_positional_list_store_unit
// Self-checking testbench of the positional list store unit.
// ----------------------------------------------------------------------------
// A table of directed requests runs first: an empty list, the value extremes,
// bad positions, a full list and views of 0, 2, 16 and 14 entries. Some rows carry
// hand-written results. Then about 430 random requests follow, in phases
// that lean towards filling, draining or a balance of the two. Every result
// is checked field by field against a shadow copy of the list. Both channels
// idle at random. The result side also holds off once for a long stretch, and
// the request side pauses once until every result has come.
// ----------------------------------------------------------------------------
module tb_positional_list_store_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import plsu_pkg::*;

	localparam int          RANDOM_ITEMS = 430;
	localparam int          HOLD_AT      = 100;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          PAUSE_AT     = 250;
	localparam int          TAIL_CYCLES  = 20;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          PLAN_ROWS    = 20;

	typedef enum {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BALANCED
	} mix_t;

	typedef struct {
		status_t             status;
		logic [VAL_W-1:0]    entry_value;
		logic [EIDX_W-1:0]   entry_index;
		logic [ECNT_W-1:0]   entry_count;
		logic                last;
	} list_result_t;

	typedef struct packed {
		req_t                kind;
		logic [POS_W-1:0]    position;
		logic [VAL_W-1:0]    value;
		logic [4:0]          reps;
		logic                known;
		status_t             status;
		logic [ECNT_W-1:0]   count;
	} plan_row_t;

	plan_row_t plan [PLAN_ROWS] = '{
		'{REQ_VIEW,   8'd0,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,  7'd0},
		'{REQ_UPDATE, 8'd0,   32'h1234_5678, 5'd1,  1'b1, ST_BADPOS, 7'd0},
		'{REQ_DELETE, 8'd255, 32'h0000_0000, 5'd1,  1'b1, ST_BADPOS, 7'd0},
		'{REQ_APPEND, 8'd0,   32'h8000_0000, 5'd1,  1'b1, ST_OK,     7'd1},
		'{REQ_APPEND, 8'd0,   32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,     7'd2},
		'{REQ_UPDATE, 8'd1,   32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,     7'd2},
		'{REQ_UPDATE, 8'd2,   32'h0000_0000, 5'd1,  1'b1, ST_BADPOS, 7'd2},
		'{REQ_VIEW,   8'd0,   32'h0000_0000, 5'd1,  1'b0, ST_OK,     7'd0},
		'{REQ_DELETE, 8'd0,   32'h0000_0000, 5'd1,  1'b1, ST_OK,     7'd1},
		'{REQ_DELETE, 8'd1,   32'h0000_0000, 5'd1,  1'b1, ST_BADPOS, 7'd1},
		'{REQ_APPEND, 8'd0,   32'h0000_0000, 5'd15, 1'b0, ST_OK,     7'd0},
		'{REQ_APPEND, 8'd0,   32'h0000_0000, 5'd1,  1'b1, ST_FULL,   7'd16},
		'{REQ_VIEW,   8'd0,   32'h0000_0000, 5'd1,  1'b0, ST_OK,     7'd0},
		'{REQ_UPDATE, 8'd15,  32'h0000_0000, 5'd1,  1'b1, ST_OK,     7'd16},
		'{REQ_UPDATE, 8'd255, 32'hAAAA_AAAA, 5'd1,  1'b1, ST_BADPOS, 7'd16},
		'{REQ_DELETE, 8'd15,  32'h0000_0000, 5'd1,  1'b1, ST_OK,     7'd15},
		'{REQ_DELETE, 8'd0,   32'h0000_0000, 5'd1,  1'b1, ST_OK,     7'd14},
		'{REQ_VIEW,   8'd0,   32'h0000_0000, 5'd1,  1'b0, ST_OK,     7'd0},
		'{REQ_UPDATE, 8'd7,   32'h5555_5555, 5'd1,  1'b1, ST_OK,     7'd14},
		'{REQ_DELETE, 8'd14,  32'h0000_0000, 5'd1,  1'b1, ST_BADPOS, 7'd14}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycle_count = 0;
	int          mismatches  = 0;
	int          hold_requests = 0;
	bit          quiet = 1'b0;

	logic [VAL_W-1:0] shadow_entries [DEPTH];
	int               shadow_count = 0;
	list_result_t     results_due [$];

	plsu_req_if req_if ();
	plsu_rsp_if rsp_if ();

	positional_list_store_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("positional_list_store_unit: mismatch");
			$finish;
		end
	end

	task automatic list_apply(req_t kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		list_result_t r;
		r.status      = ST_OK;
		r.entry_value = '0;
		r.entry_index = '0;
		r.entry_count = '0;
		r.last        = 1'b1;
		case (kind)
			REQ_VIEW: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
					results_due.push_back(r);
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						r.entry_value = shadow_entries[i];
						r.entry_index = EIDX_W'(i);
						r.entry_count = ECNT_W'(shadow_count);
						r.last        = (i == shadow_count - 1);
						results_due.push_back(r);
					end
				end
			end
			REQ_APPEND: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_entries[shadow_count] = val;
					shadow_count++;
				end
				r.entry_count = ECNT_W'(shadow_count);
				results_due.push_back(r);
			end
			REQ_UPDATE: begin
				if (int'(pos) >= shadow_count)
					r.status = ST_BADPOS;
				else
					shadow_entries[pos] = val;
				r.entry_count = ECNT_W'(shadow_count);
				results_due.push_back(r);
			end
			default: begin
				if (int'(pos) >= shadow_count) begin
					r.status = ST_BADPOS;
				end else begin
					for (int i = int'(pos); i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_count--;
				end
				r.entry_count = ECNT_W'(shadow_count);
				results_due.push_back(r);
			end
		endcase
	endtask

	// Call at a rising edge; returns at the edge of the transfer.
	task automatic offer(req_t kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		req_if.valid    <= 1'b1;
		req_if.req_type <= kind;
		req_if.position <= pos;
		req_if.value    <= val;
		do @(posedge clk); while (!req_if.ready);
		list_apply(kind, pos, val);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 25);
	endfunction

	task automatic idle_sender(int cycles);
		if (cycles > 0) begin
			req_if.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7 && shadow_count > 0)
			return POS_W'($urandom_range(0, shadow_count - 1));
		else if (r < 9)
			return POS_W'(shadow_count);
		else
			return POS_W'($urandom_range(0, 255));
	endfunction

	function automatic req_t pick_kind(mix_t mix);
		int r;
		int to_append;
		int to_update;
		int to_delete;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  begin to_append = 60; to_update = 75; to_delete = 85; end
			MIX_DRAIN: begin to_append = 20; to_update = 35; to_delete = 80; end
			default:   begin to_append = 35; to_update = 55; to_delete = 80; end
		endcase
		if (r < to_append)
			return REQ_APPEND;
		else if (r < to_update)
			return REQ_UPDATE;
		else if (r < to_delete)
			return REQ_DELETE;
		else
			return REQ_VIEW;
	endfunction

	initial begin : result_sink
		int           stall_left;
		int           holds_seen;
		list_result_t due;
		stall_left = 0;
		holds_seen = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				if (results_due.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatches++;
				end else begin
					due = results_due.pop_front();
					if (rsp_if.status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, rsp_if.status);
						mismatches++;
					end
					if (rsp_if.entry_value !== due.entry_value) begin
						$error("entry_value: expected %0d, got %0d",
							$signed(due.entry_value), $signed(rsp_if.entry_value));
						mismatches++;
					end
					if (rsp_if.entry_index !== due.entry_index) begin
						$error("entry_index: expected %0d, got %0d",
							due.entry_index, rsp_if.entry_index);
						mismatches++;
					end
					if (rsp_if.entry_count !== due.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							due.entry_count, rsp_if.entry_count);
						mismatches++;
					end
					if (rsp_if.last !== due.last) begin
						$error("last: expected %0d, got %0d", due.last, rsp_if.last);
						mismatches++;
					end
				end
			end
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	initial begin : request_source
		list_result_t     typed;
		mix_t             mix;
		logic [VAL_W-1:0] val;
		int               sent;
		int               phase_len;
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.req_type = REQ_APPEND;
		req_if.position = '0;
		req_if.value    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[n]) begin
			for (int k = 0; k < int'(plan[n].reps); k++) begin
				val = (plan[n].reps > 1) ? VAL_W'($urandom()) : plan[n].value;
				offer(plan[n].kind, plan[n].position, val);
				if (plan[n].known) begin
					typed.status      = plan[n].status;
					typed.entry_value = '0;
					typed.entry_index = '0;
					typed.entry_count = plan[n].count;
					typed.last        = 1'b1;
					void'(results_due.pop_back());
					results_due.push_back(typed);
				end
				idle_sender(pick_gap());
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mix       = mix_t'($urandom_range(0, 2));
			quiet     = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 50);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				offer(pick_kind(mix), pick_position(), VAL_W'($urandom()));
				sent++;
				if (sent == HOLD_AT)
					hold_requests++;
				if (sent == PAUSE_AT) begin
					req_if.valid <= 1'b0;
					do @(posedge clk); while (results_due.size() != 0);
				end else begin
					idle_sender(pick_gap());
				end
			end
		end

		req_if.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("positional_list_store_unit: match");
		else
			$display("positional_list_store_unit: mismatch");
		$finish;
	end

endmodule
